[rtl/fpcp_pkg.sv]
package fpcp_pkg;

   // Frame layout
   localparam int ADDR_POS      = 2;
   localparam int LEN_POS       = 4;
   localparam int HDR_BYTES     = 5;   // first payload byte index
   localparam int OVERHEAD      = 6;   // header plus crc byte
   localparam int MSG_BYTES     = 3;

   // Reflected CRC-8, polynomial 0x8C, init 0
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // floor(x / 3) for 8-bit x as (x * 171) >> 9
   localparam int DIV3_MUL   = 171;
   localparam int DIV3_SHIFT = 9;

   // message count: at most 255 / 3 = 85
   localparam int CNT_W = 7;

   localparam logic [7:0] START_RESET = 8'h06;
   localparam logic [7:0] RCV_RESET   = 8'h01;

   typedef enum logic {
      REG_START_MARKER  = 1'b0,
      REG_RECEIVER_ADDR = 1'b1
   } csr_index_type;

   typedef enum logic {
      REQ_PUSH  = 1'b0,
      REQ_CLEAR = 1'b1
   } req_kind_type;

   // one finished frame waiting for emission
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] cnt;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

[rtl/fpcp_queue.sv]
module fpcp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  fpcp_pkg::job_type       push_job,
   input  logic                    pop,
   output fpcp_pkg::job_type       head,
   output fpcp_pkg::queue_stat_type stat
);

   fpcp_pkg::job_type job_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   assign head       = job_ff[rp_ff];
   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wp_ff] <= push_job;
      end
   end

endmodule

[rtl/fpcp_front.sv]
module fpcp_front #(
   parameter int STORE_BYTES = 64,
   localparam int IW = $clog2(STORE_BYTES),
   localparam int FW = $clog2(STORE_BYTES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tuser,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [7:0]               csr_data,
   input  fpcp_pkg::queue_stat_type q_stat,
   output logic                     push,
   output fpcp_pkg::job_type        push_job,
   output logic                     wr_en,
   output logic                     wr_bank,
   output logic [IW-1:0]            wr_idx,
   output logic [7:0]               wr_data
);

   logic [7:0]    start_ff, start_in;
   logic [7:0]    rcv_ff, rcv_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    crc_ff, crc_in;
   logic          bank_ff, bank_in;
   logic [7:0]    prev_ff;
   logic [7:0]    addr_ff;
   logic [7:0]    len_ff;

   logic                       accept, is_clear, store_ok, frame_ok;
   logic [7:0]                 crc_next;
   logic [15:0]                div_prod;
   logic [fpcp_pkg::CNT_W-1:0] msg_cnt;

   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = data;
      for (int b = 0; b < 8; b++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ fpcp_pkg::CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

   assign req_tready = ~q_stat.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & req_tready;
   assign is_clear   = (req_tuser == fpcp_pkg::REQ_CLEAR);

   always_comb begin
      store_ok = accept && !is_clear
                 && !((fill_ff == '0) && (req_tdata != start_ff))
                 && (fill_ff < FW'(STORE_BYTES));
      // fold the previous byte once it is known not to be the crc byte
      crc_next = (fill_ff > FW'(fpcp_pkg::HDR_BYTES)) ? crc_fold(crc_ff, prev_ff) : crc_ff;
      frame_ok = (fill_ff >= FW'(fpcp_pkg::HDR_BYTES))
                 && (addr_ff == rcv_ff)
                 && ((9'(len_ff) + 9'(fpcp_pkg::OVERHEAD)) == (9'(fill_ff) + 9'd1))
                 && (crc_next == req_tdata);
      div_prod = 16'(len_ff) * 16'(fpcp_pkg::DIV3_MUL);
      msg_cnt  = fpcp_pkg::CNT_W'(div_prod >> fpcp_pkg::DIV3_SHIFT);
   end

   assign push          = store_ok && frame_ok && (msg_cnt != '0);
   assign push_job.bank = bank_ff;
   assign push_job.cnt  = msg_cnt;
   assign wr_en         = store_ok;
   assign wr_bank       = bank_ff;
   assign wr_idx        = IW'(fill_ff);
   assign wr_data       = req_tdata;

   always_comb begin
      start_in = start_ff;
      rcv_in   = rcv_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == fpcp_pkg::REG_START_MARKER) begin
            start_in = csr_data;
         end else begin
            rcv_in = csr_data;
         end
      end
      fill_in = fill_ff;
      crc_in  = crc_ff;
      bank_in = push ? ~bank_ff : bank_ff;
      if (accept && is_clear) begin
         fill_in = '0;
         crc_in  = '0;
      end else if (store_ok) begin
         if (frame_ok) begin
            fill_in = '0;
            crc_in  = '0;
         end else begin
            fill_in = fill_ff + FW'(1);
            crc_in  = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= fpcp_pkg::START_RESET;
         rcv_ff   <= fpcp_pkg::RCV_RESET;
         fill_ff  <= '0;
         crc_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         rcv_ff   <= rcv_in;
         fill_ff  <= fill_in;
         crc_ff   <= crc_in;
         bank_ff  <= bank_in;
      end
   end

   // header copies and last stored byte
   always_ff @(posedge clock) begin
      if (store_ok) begin
         prev_ff <= req_tdata;
         if (fill_ff == FW'(fpcp_pkg::ADDR_POS)) begin
            addr_ff <= req_tdata;
         end
         if (fill_ff == FW'(fpcp_pkg::LEN_POS)) begin
            len_ff <= req_tdata;
         end
      end
   end

endmodule

[rtl/fpcp_back.sv]
module fpcp_back #(
   parameter int STORE_BYTES = 64,
   localparam int IW = $clog2(STORE_BYTES)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic                     wr_bank,
   input  logic [IW-1:0]            wr_idx,
   input  logic [7:0]               wr_data,
   input  fpcp_pkg::queue_stat_type q_stat,
   input  fpcp_pkg::job_type        q_head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [23:0]              rsp_tdata,
   output logic                     rsp_tlast
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_EMIT
   } state_type;

   logic [7:0] mem [2][STORE_BYTES];

   state_type                  state_ff;
   logic                       bank_ff;
   logic [fpcp_pkg::CNT_W-1:0] cnt_ff;
   logic [fpcp_pkg::CNT_W-1:0] msg_ff;
   logic [IW-1:0]              ptr_ff;
   logic [7:0]                 b0_ff, b1_ff, rd_data_ff;
   logic                       rsp_valid_ff, rsp_last_ff;
   logic [23:0]                rsp_data_ff;

   logic rd_en, out_free, last_msg, rsp_valid_in;

   assign rd_en    = (state_ff == ST_RD0) || (state_ff == ST_RD1) || (state_ff == ST_RD2);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last_msg = ((msg_ff + fpcp_pkg::CNT_W'(1)) == cnt_ff);
   assign pop      = (state_ff == ST_EMIT) && out_free && last_msg;

   // new message loads the output stage, otherwise it holds until taken
   assign rsp_valid_in = ((state_ff == ST_EMIT) && out_free) || (rsp_valid_ff && !rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // two banks: front fills one while this side reads the other
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_bank][wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[bank_ff][ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  bank_ff  <= q_head.bank;
                  cnt_ff   <= q_head.cnt;
                  msg_ff   <= '0;
                  ptr_ff   <= IW'(fpcp_pkg::HDR_BYTES);
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               ptr_ff   <= ptr_ff + IW'(1);
               state_ff <= ST_RD1;
            end
            ST_RD1: begin
               b0_ff    <= rd_data_ff;
               ptr_ff   <= ptr_ff + IW'(1);
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               b1_ff    <= rd_data_ff;
               ptr_ff   <= ptr_ff + IW'(1);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_data_ff  <= {rd_data_ff, b1_ff, b0_ff};
                  rsp_last_ff  <= last_msg;
                  msg_ff       <= msg_ff + fpcp_pkg::CNT_W'(1);
                  state_ff     <= last_msg ? ST_IDLE : ST_RD0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/framed_packet_crc8_parser_unit.sv]
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata: rx_byte; tuser: req_type (1 = clear)
// rsp      out  rsp_tvalid/rsp_tready  tdata: address, first, second; tlast: last msg
// csr      in   csr_valid/csr_ready    csr_index: 0 start marker, 1 rx address
//
// Bytes are taken one per cycle while fewer than two good frames wait for emission;
// req_tready drops only when both store banks hold unsent frames.
// Each message takes states ST_RD0, ST_RD1, ST_RD2 and ST_EMIT on the single store read port, plus any rsp stall.
// The frame is checked in the cycle its crc byte arrives; the first message then passes
// the queue, states ST_IDLE, ST_RD0, ST_RD1, ST_RD2 and ST_EMIT, and the rsp output register.
// Reset is synchronous; the store is not cleared (never read unwritten).
module framed_packet_crc8_parser_unit #(
   parameter int STORE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] msg_address, [15:8] msg_first, [23:16] msg_second
   output logic        rsp_tlast,   // last_message
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   localparam int IW = $clog2(STORE_BYTES);

   fpcp_pkg::queue_stat_type q_stat;
   fpcp_pkg::job_type        push_job, q_head;
   logic                     push, pop;
   logic                     wr_en, wr_bank;
   logic [IW-1:0]            wr_idx;
   logic [7:0]               wr_data;

   // front: framing, header capture, running crc, store writes
   fpcp_front #(.STORE_BYTES(STORE_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data)
   );

   // good frames waiting for emission, one per store bank
   fpcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   // back: walks the stored payload and emits messages
   fpcp_back #(.STORE_BYTES(STORE_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_bank    (wr_bank),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/fpcp_checker.sv]
module fpcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic        csr_index,
   input logic [7:0]  csr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // a reset cycle empties the output stage
   a_rst_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // queue is empty after a reset cycle, so bytes are taken at once
   a_rst_req: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req not ready after reset");

   // register writes are never held off
   a_csr_rdy: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write stalled");

endmodule

bind framed_packet_crc8_parser_unit fpcp_checker u_fpcp_checker (.*);
